/* rtl/frt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_pkg
// shared types, widths and constants of the fragment reassembly tracker
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int TS_W  = 64;  // frame timestamp
  localparam int FLD_W = 16;  // header fields and stride register
  localparam int LEN_W = 22;  // offsets and frame length
  localparam int PROD_W = 2 * FLD_W;

  localparam int DEF_MAX_FRAGMENTS = 64;
  localparam int HEADER_BYTES      = 20;

  localparam logic [FLD_W-1:0] MAX_BODY_LENGTH_RESET = 16'd1400;

  typedef enum logic [1:0] {
    STATUS_NEW       = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_LEN_ERR   = 2'd2,
    STATUS_RANGE_ERR = 2'd3
  } status_t;

  // one parsed fragment header
  typedef struct packed {
    logic [TS_W-1:0]  frame_timestamp;
    logic [FLD_W-1:0] fragment_index;
    logic [FLD_W-1:0] fragment_count;
    logic [FLD_W-1:0] body_length;
    logic [FLD_W-1:0] received_length;
  } frag_t;

  // header checks and products, independent of tracking state
  typedef struct packed {
    logic             len_err;
    logic             range_err;
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] last_length;
  } class_t;

  // one result item
  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] write_offset;
    logic             frame_done;
    logic [LEN_W-1:0] frame_length;
    logic [TS_W-1:0]  frame_timestamp;
  } result_t;

endpackage

/* rtl/frt_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_classify
// header sanity checks, body write offset and candidate frame length
// ----------------------------------------------------------------------------
module frt_classify #(
  parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS
) (
  input  frt_pkg::frag_t                frag,
  input  logic [frt_pkg::FLD_W-1:0]     max_body_length,
  output frt_pkg::class_t               cls
);

  localparam logic [frt_pkg::FLD_W:0] MAX_CNT = (frt_pkg::FLD_W + 1)'(MAX_FRAGMENTS);
  localparam logic [frt_pkg::FLD_W:0] HDR     = (frt_pkg::FLD_W + 1)'(frt_pkg::HEADER_BYTES);

  logic [frt_pkg::FLD_W:0]    total_len;
  logic [frt_pkg::FLD_W-1:0]  cnt_m1;
  logic [frt_pkg::PROD_W-1:0] offset_prod;
  logic [frt_pkg::PROD_W-1:0] last_prod;
  logic [frt_pkg::PROD_W-1:0] last_sum;

  assign total_len = HDR + {1'b0, frag.body_length};
  assign cnt_m1    = frag.fragment_count - 1'b1;

  assign offset_prod = frag.fragment_index * max_body_length;
  assign last_prod   = cnt_m1 * max_body_length;
  assign last_sum    = last_prod + {{frt_pkg::FLD_W{1'b0}}, frag.body_length};

  always_comb begin
    cls.len_err     = total_len != {1'b0, frag.received_length};
    cls.range_err   = (frag.fragment_count == '0) ||
                      ({1'b0, frag.fragment_count} > MAX_CNT) ||
                      (frag.fragment_index >= frag.fragment_count);
    cls.offset      = offset_prod[frt_pkg::LEN_W-1:0];
    cls.last_length = last_sum[frt_pkg::LEN_W-1:0];
  end

endmodule

/* rtl/frt_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_tracker
// per-frame seen bitmap, seen count and latched length; builds the result
// ----------------------------------------------------------------------------
module frt_tracker #(
  parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  frt_pkg::frag_t  frag,
  input  frt_pkg::class_t cls,
  output frt_pkg::result_t res
);

  localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);

  logic [frt_pkg::TS_W-1:0]  tracked_timestamp;
  logic                      tracking_valid;
  logic [MAX_FRAGMENTS-1:0]  seen_flags;
  logic [CNT_W-1:0]          seen_total;
  logic [frt_pkg::LEN_W-1:0] pending_length;

  logic [IDX_W-1:0]          idx_sel;
  logic                      restart;
  logic                      flag_hit;
  logic                      is_last;
  logic [frt_pkg::LEN_W-1:0] pending_eff;
  logic [CNT_W-1:0]          total_new;
  logic                      done;
  logic                      bad;

  assign idx_sel  = frag.fragment_index[IDX_W-1:0];
  assign bad      = cls.len_err || cls.range_err;
  assign restart  = !tracking_valid || (tracked_timestamp != frag.frame_timestamp);
  assign flag_hit = !restart && seen_flags[idx_sel];
  assign is_last  = frag.fragment_index == (frag.fragment_count - 1'b1);
  assign pending_eff = is_last ? cls.last_length : (restart ? '0 : pending_length);
  assign total_new   = (restart ? '0 : seen_total) + 1'b1;
  assign done = (frt_pkg::FLD_W + 1)'(total_new) == {1'b0, frag.fragment_count};

  always_comb begin
    res = '0;
    priority if (cls.len_err) begin
      res.status = frt_pkg::STATUS_LEN_ERR;
    end else if (cls.range_err) begin
      res.status = frt_pkg::STATUS_RANGE_ERR;
    end else if (flag_hit) begin
      res.status       = frt_pkg::STATUS_DUPLICATE;
      res.write_offset = cls.offset;
    end else begin
      res.status       = frt_pkg::STATUS_NEW;
      res.write_offset = cls.offset;
      res.frame_done   = done;
      if (done) begin
        res.frame_length    = pending_eff;
        res.frame_timestamp = frag.frame_timestamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_timestamp <= '0;
      tracking_valid    <= 1'b0;
      seen_flags        <= '0;
      seen_total        <= '0;
      pending_length    <= '0;
    end else if (advance && !bad && !flag_hit) begin
      tracked_timestamp <= frag.frame_timestamp;
      if (done) begin
        // frame complete, drop all tracking
        tracking_valid <= 1'b0;
        seen_flags     <= '0;
        seen_total     <= '0;
        pending_length <= '0;
      end else begin
        tracking_valid <= 1'b1;
        seen_flags     <= (restart ? '0 : seen_flags) | (MAX_FRAGMENTS'(1) << idx_sel);
        seen_total     <= total_new;
        pending_length <= pending_eff;
      end
    end
  end

endmodule

/* rtl/fragment_frame_reassembly_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_frame_reassembly_tracker_core
// tracks fragments of one frame and reports buffer offsets and completion
// ----------------------------------------------------------------------------
// usage
//   fragment channel: one parsed header per request (fragment_valid /
//   fragment_stall); result channel: one result per request (result_valid /
//   result_stall). the receiver of each channel drives its stall.
//   cfg_write_enable loads cfg_write_data into the stride register
//   (max body length); write it only while no request is in flight.
// pipeline
//   a request taken into the input register is checked and tracked in one
//   pass of logic, and its result is registered in the output register; one
//   request per cycle is sustained while result_stall is low.
//   the pass holds two 16x16 multiplies and the bitmap test and update.
// stall
//   a stalled result holds in the output register; the input register keeps
//   accepting until it is also full, then fragment_stall rises (it follows
//   result_stall combinationally, so no request is lost or repeated).
// reset
//   rst clears the pipeline, the bitmap, seen count and latched length, and
//   sets the stride to 1400.
// ----------------------------------------------------------------------------
module fragment_frame_reassembly_tracker_core #(
  parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write_enable,
  input  logic [frt_pkg::FLD_W-1:0] cfg_write_data,
  // fragment header requests
  input  logic                      fragment_valid,
  output logic                      fragment_stall,
  input  logic [frt_pkg::TS_W-1:0]  frame_timestamp_in,
  input  logic [frt_pkg::FLD_W-1:0] fragment_index,
  input  logic [frt_pkg::FLD_W-1:0] fragment_count,
  input  logic [frt_pkg::FLD_W-1:0] body_length,
  input  logic [frt_pkg::FLD_W-1:0] received_length,
  // results
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [1:0]                status,
  output logic [frt_pkg::LEN_W-1:0] write_offset,
  output logic                      frame_done,
  output logic [frt_pkg::LEN_W-1:0] frame_length,
  output logic [frt_pkg::TS_W-1:0]  frame_timestamp_out
);

  // stride register
  logic [frt_pkg::FLD_W-1:0] max_body_length;

  // input register
  logic           in_valid;
  frt_pkg::frag_t in_frag;

  // output register
  frt_pkg::result_t result;

  frt_pkg::class_t  cls;
  frt_pkg::result_t res_next;
  logic             out_load;
  logic             advance;

  assign out_load       = !result_valid || !result_stall;
  assign advance        = in_valid && out_load;
  assign fragment_stall = in_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= frt_pkg::MAX_BODY_LENGTH_RESET;
    end else if (cfg_write_enable) begin
      max_body_length <= cfg_write_data;
    end
  end

  // input register loads whenever it is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!fragment_stall) begin
      in_valid <= fragment_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!fragment_stall && fragment_valid) begin
      in_frag.frame_timestamp <= frame_timestamp_in;
      in_frag.fragment_index  <= fragment_index;
      in_frag.fragment_count  <= fragment_count;
      in_frag.body_length     <= body_length;
      in_frag.received_length <= received_length;
    end
  end

  // header checks and multiplies
  frt_classify #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_classify (
    .frag           (in_frag),
    .max_body_length(max_body_length),
    .cls            (cls)
  );

  // bitmap and frame state, updated as the request moves to the output
  frt_tracker #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .frag   (in_frag),
    .cls    (cls),
    .res    (res_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  assign status              = result.status;
  assign write_offset        = result.write_offset;
  assign frame_done          = result.frame_done;
  assign frame_length        = result.frame_length;
  assign frame_timestamp_out = result.frame_timestamp;

endmodule
